>>> sv/three_stream_timestamp_aligner_core_macros.svh
// Assertion macros used by the timestamp aligner datapath.
`ifndef THREE_STREAM_TIMESTAMP_ALIGNER_CORE_MACROS_SVH
`define THREE_STREAM_TIMESTAMP_ALIGNER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define TSA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define TSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/tsa_pkg.sv
// Types and constants of the three-stream timestamp aligner.
package tsa_pkg;

   localparam int TIME_BITS    = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int CSR_BITS     = 32;
   localparam int LIMIT_BITS   = 4;
   localparam int NUM_STREAMS  = 3;

   localparam logic [TIME_BITS-1:0]  MAX_AGE_RESET    = 32'd100;
   localparam logic [TIME_BITS-1:0]  GUARD_TIME_RESET = 32'd5;
   localparam logic [LIMIT_BITS-1:0] LIST_LIMIT_RESET = 4'd5;

   // Function code; sample codes double as stream index.
   typedef enum logic [1:0] {
      FUNC_RIGHT = 2'd0,
      FUNC_LEFT  = 2'd1,
      FUNC_FIELD = 2'd2,
      FUNC_PURGE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_MAX_AGE    = 2'd0,
      CSR_GUARD_TIME = 2'd1,
      CSR_LIST_LIMIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      func_type                func;
      logic [TIME_BITS-1:0]    sample_time;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [TIME_BITS-1:0]    now;
   } req_type;

   typedef struct packed {
      logic [TIME_BITS-1:0]    tuple_time;
      logic                    right_valid;
      logic [PAYLOAD_BITS-1:0] right_payload;
      logic                    left_valid;
      logic [PAYLOAD_BITS-1:0] left_payload;
      logic                    field_valid;
      logic [PAYLOAD_BITS-1:0] field_payload;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture the input transaction
      logic push;       // append sample to its history
      logic trigger;    // record trigger, start a scan
      logic purge_rd;   // read newest entry of each history
      logic purge_chk;  // age check on the newest entries
      logic scan_rd;    // read one entry of each history
      logic load_rsp;   // move result into the output register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_purge;
      logic trig_ok;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

>>> sv/tsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tsa_ctrl.sv
// Sequencer of the timestamp aligner: accept, append or purge, scan, hand off.
module tsa_ctrl
   import tsa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_EXEC    = 7'b0000010,
      ST_PURGE   = 7'b0000100,
      ST_SCAN    = 7'b0001000,
      ST_DRAIN_A = 7'b0010000,
      ST_DRAIN_B = 7'b0100000,
      ST_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_purge) begin
               cmd.purge_rd = 1'b1;
               state_in     = ST_PURGE;
            end else begin
               cmd.push = 1'b1;
               if (status.trig_ok) begin
                  cmd.trigger = 1'b1;
                  state_in    = ST_SCAN;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PURGE: begin
            cmd.purge_chk = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN_A;
            end
         end
         // the drain states let the RAM read data and the distance stage drain
         ST_DRAIN_A: state_in = ST_DRAIN_B;
         ST_DRAIN_B: state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/tsa_dpath.sv
// Datapath of the timestamp aligner: histories, trigger check, nearest search, result.
`include "three_stream_timestamp_aligner_core_macros.svh"

module tsa_dpath
   import tsa_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_type               req_data,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [CSR_BITS-1:0]   csr_wdata,
   input  cmd_type               cmd,
   output status_type            status
);

   localparam int PTR_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int LCMP_W  = (CNT_W > LIMIT_BITS) ? CNT_W : LIMIT_BITS;
   localparam int ENTRY_W = TIME_BITS + PAYLOAD_BITS;

   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] r;
      r = (s >= SUM_W'(HISTORY_DEPTH)) ? s - SUM_W'(HISTORY_DEPTH) : s;
      return r[PTR_W-1:0];
   endfunction

   // configuration
   logic [TIME_BITS-1:0]  max_age_ff;
   logic [TIME_BITS-1:0]  guard_time_ff;
   logic [LIMIT_BITS-1:0] list_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff    <= MAX_AGE_RESET;
         guard_time_ff <= GUARD_TIME_RESET;
         list_limit_ff <= LIST_LIMIT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MAX_AGE:    max_age_ff    <= csr_wdata[TIME_BITS-1:0];
            CSR_GUARD_TIME: guard_time_ff <= csr_wdata[TIME_BITS-1:0];
            CSR_LIST_LIMIT: list_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective list limit, clamped to 1..HISTORY_DEPTH
   logic [LCMP_W-1:0] lim_ext;
   logic [CNT_W-1:0]  lim_eff;

   always_comb begin
      lim_ext = LCMP_W'(list_limit_ff);
      if (lim_ext == '0) begin
         lim_eff = CNT_W'(1);
      end else if (lim_ext > LCMP_W'(HISTORY_DEPTH)) begin
         lim_eff = CNT_W'(HISTORY_DEPTH);
      end else begin
         lim_eff = lim_ext[CNT_W-1:0];
      end
   end

   // captured transaction and trigger state
   req_type              req_ff;
   logic [TIME_BITS-1:0] last_trigger_ff;
   logic [TIME_BITS-1:0] trig_time_ff;
   logic [PTR_W-1:0]     scan_idx_ff;
   logic                 rd_vld_ff;

   logic [CNT_W-1:0]     count_q [NUM_STREAMS];
   logic [1:0]           stream_sel;
   logic [TIME_BITS-1:0] trig_time;
   logic [TIME_BITS-1:0] trig_diff;
   logic                 stream_trig;

   assign stream_sel = req_ff.func;
   assign trig_time  = (req_ff.sample_time == '0) ? req_ff.now : req_ff.sample_time;
   assign trig_diff  = trig_time - last_trigger_ff;

   always_comb begin
      unique case (req_ff.func)
         FUNC_RIGHT: stream_trig = 1'b1;
         FUNC_LEFT:  stream_trig = (count_q[0] == '0);
         FUNC_FIELD: stream_trig = (count_q[0] == '0) && (count_q[1] == '0);
         default:    stream_trig = 1'b0;
      endcase
   end

   assign status.is_purge  = (req_ff.func == FUNC_PURGE);
   // all-ones time never aligns; a trigger behind or too close to the last is dropped
   assign status.trig_ok   = stream_trig && (trig_time != '1) &&
                             !trig_diff[TIME_BITS-1] && (trig_diff >= guard_time_ff);
   assign status.scan_last = (scan_idx_ff == PTR_W'(HISTORY_DEPTH - 1));
   assign status.out_free  = !rsp_valid || !rsp_stall;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.trigger) begin
         trig_time_ff <= trig_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_trigger_ff <= '0;
         scan_idx_ff     <= '0;
         rd_vld_ff       <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         if (cmd.trigger) begin
            last_trigger_ff <= trig_time;
            scan_idx_ff     <= '0;
         end else if (cmd.scan_rd) begin
            scan_idx_ff <= scan_idx_ff + PTR_W'(1);
         end
      end
   end

   // per-stream history and nearest search
   logic                    res_valid [NUM_STREAMS];
   logic [PAYLOAD_BITS-1:0] res_pay   [NUM_STREAMS];

   for (genvar s = 0; s < NUM_STREAMS; s++) begin : g_stream
      logic [PTR_W-1:0]        head_ff;
      logic [CNT_W-1:0]        count_ff;
      logic                    in_range_ff;
      logic                    mag_vld_ff;
      logic [TIME_BITS-1:0]    mag_ff;
      logic [PAYLOAD_BITS-1:0] mag_pay_ff;
      logic                    found_ff;
      logic [TIME_BITS-1:0]    best_ff;
      logic [PAYLOAD_BITS-1:0] best_pay_ff;

      logic [PTR_W-1:0]        head_push;
      logic [CNT_W-1:0]        cnt_kept;
      logic [SUM_W-1:0]        drop;
      logic [PTR_W-1:0]        wr_addr;
      logic [PTR_W-1:0]        rd_addr;
      logic                    wr_en;
      logic [ENTRY_W-1:0]      rd_data;
      logic [TIME_BITS-1:0]    ent_time;
      logic [PAYLOAD_BITS-1:0] ent_pay;
      logic [TIME_BITS-1:0]    delta;
      logic [TIME_BITS-1:0]    mag;
      logic [TIME_BITS-1:0]    age;
      logic                    stale;

      // append: drop oldest entries until the new one fits under the limit
      always_comb begin
         drop = '0;
         if (count_ff >= lim_eff) begin
            drop     = SUM_W'(count_ff) + SUM_W'(1) - SUM_W'(lim_eff);
            cnt_kept = lim_eff - CNT_W'(1);
         end else begin
            cnt_kept = count_ff;
         end
         head_push = wrap_ptr(SUM_W'(head_ff) + drop);
         wr_addr   = wrap_ptr(SUM_W'(head_push) + SUM_W'(cnt_kept));
      end

      always_comb begin
         if (cmd.purge_rd) begin
            rd_addr = (count_ff == '0) ? head_ff :
                      wrap_ptr(SUM_W'(head_ff) + SUM_W'(count_ff) - SUM_W'(1));
         end else begin
            rd_addr = wrap_ptr(SUM_W'(head_ff) + SUM_W'(scan_idx_ff));
         end
      end

      assign wr_en = cmd.push && (stream_sel == 2'(s));

      tsa_ram #(
         .WIDTH (ENTRY_W),
         .DEPTH (HISTORY_DEPTH)
      ) u_hist (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data ({req_ff.sample_time, req_ff.payload}),
         .rd_en   (cmd.purge_rd || cmd.scan_rd),
         .rd_addr (rd_addr),
         .rd_data (rd_data)
      );

      assign ent_time = rd_data[ENTRY_W-1 -: TIME_BITS];
      assign ent_pay  = rd_data[PAYLOAD_BITS-1:0];
      assign delta    = trig_time_ff - ent_time;
      assign mag      = delta[TIME_BITS-1] ? (TIME_BITS'(0) - delta) : delta;
      assign age      = req_ff.now - ent_time;
      assign stale    = (count_ff != '0) && !age[TIME_BITS-1] && (age > max_age_ff);

      always_ff @(posedge clock) begin
         mag_ff     <= mag;
         mag_pay_ff <= ent_pay;
         if (mag_vld_ff && (!found_ff || (mag_ff < best_ff))) begin
            best_ff     <= mag_ff;
            best_pay_ff <= mag_pay_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            head_ff     <= '0;
            count_ff    <= '0;
            in_range_ff <= 1'b0;
            mag_vld_ff  <= 1'b0;
            found_ff    <= 1'b0;
         end else begin
            in_range_ff <= cmd.scan_rd && (SUM_W'(scan_idx_ff) < SUM_W'(count_ff));
            mag_vld_ff  <= rd_vld_ff && in_range_ff;
            if (wr_en) begin
               head_ff  <= head_push;
               count_ff <= cnt_kept + CNT_W'(1);
            end else if (cmd.purge_chk && stale) begin
               count_ff <= '0;
            end
            if (cmd.trigger) begin
               found_ff <= 1'b0;
            end else if (mag_vld_ff) begin
               found_ff <= 1'b1;
            end
         end
      end

      assign count_q[s]   = count_ff;
      assign res_valid[s] = found_ff && (best_ff <= max_age_ff);
      assign res_pay[s]   = res_valid[s] ? best_pay_ff : '0;
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.tuple_time    <= trig_time_ff;
         rsp_data_ff.right_valid   <= res_valid[0];
         rsp_data_ff.right_payload <= res_pay[0];
         rsp_data_ff.left_valid    <= res_valid[1];
         rsp_data_ff.left_payload  <= res_pay[1];
         rsp_data_ff.field_valid   <= res_valid[2];
         rsp_data_ff.field_payload <= res_pay[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a purge only ever clears a count, so no bit of any count can appear
   logic [NUM_STREAMS*CNT_W-1:0] cnt_all;
   logic                         right_clean;

   assign cnt_all     = {count_q[2], count_q[1], count_q[0]};
   assign right_clean = rsp_data_ff.right_valid || (rsp_data_ff.right_payload == '0);

   `TSA_ASSERT_NEXT(a_push_nonempty, cmd.push, count_q[stream_sel] != '0, "empty after append")
   `TSA_ASSERT_NEXT(a_purge_no_grow, cmd.purge_chk, (cnt_all & ~$past(cnt_all)) == '0, "grew")
   `TSA_ASSERT_IMPL(a_rsp_free, cmd.load_rsp, !(rsp_valid_ff && rsp_stall), "result overwritten")
   `TSA_ASSERT_IMPL(a_invalid_zero, rsp_valid_ff, right_clean, "invalid right match has payload")

endmodule

>>> sv/three_stream_timestamp_aligner_core.sv
// Top level of the three-stream timestamp aligner.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  req      | req_valid / req_stall  | req_data  (func, time, payload, now)
//  rsp      | rsp_valid / rsp_stall  | rsp_data  (tuple time, 3 matches)
//  csr      | csr_write_en           | csr_index, csr_wdata
//
// One transaction at a time. A sample that does not trigger is only appended, a purge
// tick age-checks the newest entries, and a trigger scans one entry of each history per
// cycle from its RAM, then drains through ST_DRAIN_A and ST_DRAIN_B to the hand-off.
// Reset is synchronous; it empties the histories and restores register defaults.
// A stalled result stays in the output register while the next transaction is worked;
// a second result waits in the controller until the output register frees.
module three_stream_timestamp_aligner_core
   import tsa_pkg::*;
#(
   parameter int HISTORY_DEPTH = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_type             rsp_data,
   input  logic                csr_write_en,
   input  logic [1:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   tsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tsa_dpath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status)
   );

endmodule

>>> tb/sv/three_stream_timestamp_aligner_core_test.sv
// Self-checking testbench of the three-stream timestamp aligner core.
module three_stream_timestamp_aligner_core_test;
   import tsa_pkg::*;

   localparam int DEPTH      = 8;
   localparam int SETTLE_CYC = 2 * (DEPTH + 5) + 4;

   // Predicts aligned tuples and checks the ones the block returns.
   class tuple_scoreboard;
      logic [TIME_BITS-1:0]    max_age;
      logic [TIME_BITS-1:0]    guard_time;
      logic [LIMIT_BITS-1:0]   list_limit;
      logic [TIME_BITS-1:0]    hist_time [NUM_STREAMS][DEPTH];
      logic [PAYLOAD_BITS-1:0] hist_pay [NUM_STREAMS][DEPTH];
      int unsigned             hist_cnt [NUM_STREAMS];
      logic [TIME_BITS-1:0]    last_trig;
      rsp_type                 tuples_due [$];
      int unsigned             mismatches;

      function new();
         max_age    = MAX_AGE_RESET;
         guard_time = GUARD_TIME_RESET;
         list_limit = LIST_LIMIT_RESET;
         last_trig  = '0;
         mismatches = 0;
         foreach (hist_cnt[s]) hist_cnt[s] = 0;
      endfunction

      function void set_regs(logic [TIME_BITS-1:0] age, logic [TIME_BITS-1:0] guard,
                             logic [LIMIT_BITS-1:0] limit);
         max_age    = age;
         guard_time = guard;
         list_limit = limit;
      endfunction

      function int pending();
         return tuples_due.size();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      function void closest_entry(int s, logic [TIME_BITS-1:0] t, output logic hit,
                                  output logic [PAYLOAD_BITS-1:0] pay);
         logic [TIME_BITS-1:0] delta;
         logic [TIME_BITS-1:0] best;
         best = '0;
         pay  = '0;
         for (int i = 0; i < hist_cnt[s]; i++) begin
            delta = t - hist_time[s][i];
            if (delta[TIME_BITS-1]) delta = '0 - delta;
            // strict compare keeps the oldest entry on a tie
            if (i == 0 || delta < best) begin
               best = delta;
               pay  = hist_pay[s][i];
            end
         end
         hit = (hist_cnt[s] != 0) && (best <= max_age);
         if (!hit) pay = '0;
      endfunction

      function void absorb_sample(req_type item);
         int                   s;
         int unsigned          lim;
         int unsigned          c;
         int unsigned          drop;
         logic                 trig;
         logic [TIME_BITS-1:0] t;
         logic [TIME_BITS-1:0] diff;
         rsp_type              tuple;
         if (item.func == FUNC_PURGE) begin
            for (int k = 0; k < NUM_STREAMS; k++) begin
               if (hist_cnt[k] != 0) begin
                  diff = item.now - hist_time[k][hist_cnt[k] - 1];
                  if (!diff[TIME_BITS-1] && diff > max_age) hist_cnt[k] = 0;
               end
            end
            return;
         end
         s   = int'(item.func);
         lim = (list_limit == 0) ? 1 : (list_limit > DEPTH) ? DEPTH : list_limit;
         c   = hist_cnt[s];
         if (c + 1 > lim) begin
            drop = c + 1 - lim;
            for (int i = 0; i + drop < c; i++) begin
               hist_time[s][i] = hist_time[s][i + drop];
               hist_pay[s][i]  = hist_pay[s][i + drop];
            end
            c = c - drop;
         end
         hist_time[s][c] = item.sample_time;
         hist_pay[s][c]  = item.payload;
         hist_cnt[s]     = c + 1;
         case (item.func)
            FUNC_RIGHT: trig = 1'b1;
            FUNC_LEFT:  trig = (hist_cnt[0] == 0);
            default:    trig = (hist_cnt[0] == 0) && (hist_cnt[1] == 0);
         endcase
         if (!trig) return;
         t = (item.sample_time == '0) ? item.now : item.sample_time;
         if (t == '1) return;
         diff = t - last_trig;
         if (diff[TIME_BITS-1] || diff < guard_time) return;
         last_trig = t;
         tuple.tuple_time = t;
         closest_entry(0, t, tuple.right_valid, tuple.right_payload);
         closest_entry(1, t, tuple.left_valid, tuple.left_payload);
         closest_entry(2, t, tuple.field_valid, tuple.field_payload);
         tuples_due.push_back(tuple);
      endfunction

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
      endtask

      task check_tuple(rsp_type got);
         rsp_type want;
         if (tuples_due.size() == 0) begin
            report($sformatf("unexpected tuple, time %h", got.tuple_time));
            return;
         end
         want = tuples_due[0];
         tuples_due.delete(0);
         compare_field("tuple_time", got.tuple_time, want.tuple_time);
         compare_field("right_valid", 32'(got.right_valid), 32'(want.right_valid));
         compare_field("right_payload", got.right_payload, want.right_payload);
         compare_field("left_valid", 32'(got.left_valid), 32'(want.left_valid));
         compare_field("left_payload", got.left_payload, want.left_payload);
         compare_field("field_valid", 32'(got.field_valid), 32'(want.field_valid));
         compare_field("field_payload", got.field_payload, want.field_payload);
      endtask
   endclass

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   req_type             req_data     = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_en = 1'b0;
   logic [1:0]          csr_index    = '0;
   logic [CSR_BITS-1:0] csr_wdata    = '0;

   tuple_scoreboard      sb;
   logic                 gaps_on;
   logic                 stall_on;
   int                   stall_left;
   logic [TIME_BITS-1:0] base_time;

   three_stream_timestamp_aligner_core #(
      .HISTORY_DEPTH(DEPTH)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short pauses, now and then a long one
   function automatic int pick_gap(logic enabled);
      int r;
      if (!enabled) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // result side: check accepted tuples, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_tuple(rsp_data);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stall_on && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap(1'b1);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic req_type make_item(func_type f, logic [31:0] st, logic [31:0] pay,
                                         logic [31:0] now);
      req_type item;
      item.func        = f;
      item.sample_time = st;
      item.payload     = pay;
      item.now         = now;
      return item;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.absorb_sample(item);
      gap = pick_gap(gaps_on);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_tuples();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] age, input logic [31:0] guard,
                               input logic [3:0] limit);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_MAX_AGE;
      csr_wdata    <= age;
      @(posedge clock);
      csr_index <= CSR_GUARD_TIME;
      csr_wdata <= guard;
      @(posedge clock);
      csr_index <= CSR_LIST_LIMIT;
      csr_wdata <= {28'($urandom), limit};
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.set_regs(age, guard, limit);
   endtask

   // Samples cluster around a slowly advancing time so that triggers pass the
   // guard and find close neighbors; some time jumps let purges empty streams.
   function automatic req_type next_sample();
      req_type     item;
      logic [31:0] ahead;
      int          r;
      ahead = sb.last_trig - base_time;
      if (!ahead[31]) base_time = sb.last_trig;
      r = $urandom_range(0, 99);
      if (r < 85) base_time += $urandom_range(0, 15);
      else if (r < 97) base_time += $urandom_range(16, 400);
      else base_time += $urandom;
      item.payload = $urandom;
      item.now     = ($urandom_range(0, 9) == 0) ? 32'($urandom) : base_time;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         if (sb.max_age < 32'h1000_0000 && $urandom_range(0, 1) == 1) begin
            base_time += sb.max_age + $urandom_range(1, 200);
            item.now = base_time;
         end
         item.func = FUNC_PURGE;
      end else if (r < 45) begin
         item.func = FUNC_RIGHT;
      end else if (r < 73) begin
         item.func = FUNC_LEFT;
      end else begin
         item.func = FUNC_FIELD;
      end
      r = $urandom_range(0, 99);
      if (r < 72) item.sample_time = base_time + 32'($urandom_range(0, 20)) - 32'd10;
      else if (r < 84) item.sample_time = '0;
      else if (r < 90) item.sample_time = '1;
      else item.sample_time = $urandom;
      return item;
   endfunction

   task automatic run_random(input int count, input logic gaps, input logic stalls);
      gaps_on   = gaps;
      stall_on  = stalls;
      base_time = sb.last_trig + $urandom_range(32'h100, 32'h7000_0000);
      for (int n = 0; n < count; n++) begin
         send_item(next_sample());
         if ($urandom_range(0, 99) < 2) drain_tuples();
      end
      drain_tuples();
   endtask

   task automatic run_directed();
      gaps_on  = 1'b1;
      stall_on = 1'b1;
      send_item(make_item(FUNC_RIGHT, 32'd0, 32'hFFFF_FFFF, 32'd50));   // zero time uses now
      send_item(make_item(FUNC_RIGHT, 32'd52, 32'd1, 32'd52));          // inside guard
      send_item(make_item(FUNC_RIGHT, 32'hFFFF_FFFF, 32'd2, 32'd60));   // all-ones time
      send_item(make_item(FUNC_LEFT, 32'd60, 32'd3, 32'd60));           // right not empty
      send_item(make_item(FUNC_FIELD, 32'd990, 32'hA5A5_A5A5, 32'd990));
      send_item(make_item(FUNC_FIELD, 32'd1010, 32'h5A5A_5A5A, 32'd1010));
      send_item(make_item(FUNC_RIGHT, 32'd1000, 32'd0, 32'd1000));      // field tie
      send_item(make_item(FUNC_RIGHT, 32'd900, 32'd4, 32'd1001));       // goes backward
      send_item(make_item(FUNC_PURGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5000));
      send_item(make_item(FUNC_FIELD, 32'd5000, 32'd5, 32'd5000));      // field leads
      send_item(make_item(FUNC_LEFT, 32'd5010, 32'd6, 32'd5010));       // left leads
      send_item(make_item(FUNC_FIELD, 32'd5012, 32'd7, 32'd5012));
      for (int i = 0; i < 6; i++)                                       // overflow the list
         send_item(make_item(FUNC_RIGHT, 32'd5020 + 32'(10 * i), 32'd100 + 32'(i),
                             32'd5020 + 32'(10 * i)));
      send_item(make_item(FUNC_PURGE, 32'd0, 32'd0, 32'd5100));         // all still young
      send_item(make_item(FUNC_PURGE, 32'd0, 32'd0, 32'd5171));         // all expire
      send_item(make_item(FUNC_LEFT, 32'hFFFF_FFF0, 32'd8, 32'hFFFF_FFF0));
      send_item(make_item(FUNC_RIGHT, 32'd0, 32'd9, 32'h7000_0000));
      send_item(make_item(FUNC_FIELD, 32'd0, 32'd10, 32'h7000_0008));   // stored as zero
      send_item(make_item(FUNC_RIGHT, 32'h7000_0064, 32'd11, 32'h7000_0064));
      send_item(make_item(FUNC_RIGHT, 32'h7000_0069, 32'd12, 32'h7000_0069));
      drain_tuples();
   endtask

   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      sb       = new();
      gaps_on  = 1'b0;
      stall_on = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      // exact-match only, no guard, single-entry lists
      program_regs(32'd0, 32'd0, 4'd1);
      run_random(100, 1'b0, 1'b0);
      // widest settings
      program_regs(32'hFFFF_FFFF, 32'd0, 4'd8);
      run_random(100, 1'b1, 1'b1);
      // limit 0 behaves as 1 and trims the full lists
      program_regs(32'd50, 32'd2, 4'd0);
      run_random(90, 1'b1, 1'b0);
      // every trigger blocked by the guard
      program_regs(32'd20, 32'hFFFF_FFFF, 4'd3);
      run_random(30, 1'b0, 1'b1);
      program_regs(32'd300, 32'd10, 4'd15);
      run_random(110, 1'b1, 1'b1);
      program_regs(32'd100, 32'd5, 4'd5);
      run_random(110, 1'b1, 1'b1);
      program_regs(32'd30, 32'd1, 4'd2);
      run_random(110, 1'b0, 1'b1);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/tsa_pkg.sv
sv/tsa_ram.sv
sv/tsa_ctrl.sv
sv/tsa_dpath.sv
sv/three_stream_timestamp_aligner_core.sv
tb/sv/three_stream_timestamp_aligner_core_test.sv
